// File: sv/rne_pkg.sv
// shared types, constants and the numeral token table for the roman numeral encoder
`timescale 1ns / 1ps
package rne_pkg;

   localparam int VALUE_W      = 12;
   localparam int GLYPH_W      = 8;
   localparam int REQ_DATA_W   = 16;
   localparam int TOKENS       = 13;
   localparam int TOK_W        = 4;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

   localparam logic [GLYPH_W-1:0] CHAR_M    = 8'h4d;
   localparam logic [GLYPH_W-1:0] CHAR_D    = 8'h44;
   localparam logic [GLYPH_W-1:0] CHAR_C    = 8'h43;
   localparam logic [GLYPH_W-1:0] CHAR_L    = 8'h4c;
   localparam logic [GLYPH_W-1:0] CHAR_X    = 8'h58;
   localparam logic [GLYPH_W-1:0] CHAR_V    = 8'h56;
   localparam logic [GLYPH_W-1:0] CHAR_I    = 8'h49;
   localparam logic [GLYPH_W-1:0] CHAR_NONE = 8'h00;

   // tokens ordered from largest weight down
   localparam logic [VALUE_W-1:0] TOKEN_WEIGHT [TOKENS] = '{
      12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
      12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
   };

   localparam logic [GLYPH_W-1:0] TOKEN_FIRST [TOKENS] = '{
      CHAR_M, CHAR_C, CHAR_D, CHAR_C, CHAR_C, CHAR_X, CHAR_L,
      CHAR_X, CHAR_X, CHAR_I, CHAR_V, CHAR_I, CHAR_I
   };

   // CHAR_NONE marks a single-letter token
   localparam logic [GLYPH_W-1:0] TOKEN_SECOND [TOKENS] = '{
      CHAR_NONE, CHAR_M, CHAR_NONE, CHAR_D, CHAR_NONE, CHAR_C, CHAR_NONE,
      CHAR_L, CHAR_NONE, CHAR_X, CHAR_NONE, CHAR_V, CHAR_NONE
   };

   typedef struct packed {
      logic               vld;
      logic [VALUE_W-1:0] value;
   } q_entry_type;

   typedef struct packed {
      logic busy;
      logic pend;
   } back_stat_type;

endpackage

// File: sv/rne_front.sv
// front stage: takes requests, drops values with no numeral, hands the rest to the queue
`timescale 1ns / 1ps
module rne_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [rne_pkg::VALUE_W-1:0] req_value,
   input  logic                        q_ready,
   output rne_pkg::q_entry_type        q_push
);
   import rne_pkg::*;

   logic               hold_vld_ff, hold_vld_in;
   logic [VALUE_W-1:0] hold_value_ff, hold_value_in;
   logic               in_range;

   assign in_range   = (req_value != '0) && (req_value <= VALUE_MAX);
   assign req_tready = !hold_vld_ff || q_ready;

   always_comb begin
      hold_vld_in   = hold_vld_ff;
      hold_value_in = hold_value_ff;
      if (req_tready) begin
         hold_vld_in   = req_tvalid && in_range;
         hold_value_in = req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
      end else begin
         hold_vld_ff <= hold_vld_in;
      end
      hold_value_ff <= hold_value_in;
   end

   assign q_push.vld   = hold_vld_ff;
   assign q_push.value = hold_value_ff;

endmodule

// File: sv/rne_queue.sv
// short fifo of accepted values between the front and the back
`timescale 1ns / 1ps
module rne_queue #(
   parameter int DEPTH = rne_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rne_pkg::q_entry_type q_push,
   output logic                 q_ready,
   output rne_pkg::q_entry_type q_head,
   input  logic                 q_pop
);
   import rne_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [VALUE_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign q_ready      = (count_ff != CNT_FULL);
   assign do_push      = q_push.vld && q_ready;
   assign do_pop       = q_pop && (count_ff != '0);
   assign q_head.vld   = (count_ff != '0);
   assign q_head.value = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= q_push.value;
      end
   end

endmodule

// File: sv/rne_back.sv
// back stage: walks the token table and emits one numeral letter per cycle while the output is not stalled
`timescale 1ns / 1ps
module rne_back (
   input  logic                        clock,
   input  logic                        reset,
   input  rne_pkg::q_entry_type        q_head,
   output logic                        q_pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [rne_pkg::GLYPH_W-1:0] rsp_glyph,
   output logic                        rsp_last,
   output rne_pkg::back_stat_type      stat
);
   import rne_pkg::*;

   logic               busy_ff, busy_in;
   logic               pend_ff, pend_in;
   logic [TOK_W-1:0]   tok_ff, tok_in;
   logic [VALUE_W-1:0] rest_ff, rest_in;
   logic               vld_ff, vld_in;
   logic [GLYPH_W-1:0] glyph_ff, glyph_in;
   logic               last_ff, last_in;
   logic               out_free;
   logic [TOK_W-1:0]   sel;
   logic [VALUE_W-1:0] rest_next;
   logic               emit_done;

   assign out_free = !vld_ff || rsp_tready;
   assign q_pop    = !busy_ff && q_head.vld;

   // largest token that still fits the remainder
   always_comb begin
      sel = TOK_W'(TOKENS - 1);
      for (int i = TOKENS - 1; i >= 0; i--) begin
         if (rest_ff >= TOKEN_WEIGHT[i]) begin
            sel = TOK_W'(i);
         end
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      pend_in   = pend_ff;
      tok_in    = tok_ff;
      rest_in   = rest_ff;
      vld_in    = vld_ff && !rsp_tready;
      glyph_in  = glyph_ff;
      last_in   = last_ff;
      rest_next = rest_ff - TOKEN_WEIGHT[pend_ff ? tok_ff : sel];
      emit_done = (rest_next == '0);
      if (!busy_ff) begin
         if (q_head.vld) begin
            busy_in = 1'b1;
            pend_in = 1'b0;
            rest_in = q_head.value;
         end
      end else if (out_free) begin
         vld_in = 1'b1;
         if (pend_ff) begin
            // second letter of a subtractive pair
            glyph_in = TOKEN_SECOND[tok_ff];
            pend_in  = 1'b0;
            rest_in  = rest_next;
            last_in  = emit_done;
            busy_in  = !emit_done;
         end else begin
            glyph_in = TOKEN_FIRST[sel];
            tok_in   = sel;
            if (TOKEN_SECOND[sel] != CHAR_NONE) begin
               pend_in = 1'b1;
               last_in = 1'b0;
            end else begin
               rest_in = rest_next;
               last_in = emit_done;
               busy_in = !emit_done;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pend_ff <= 1'b0;
         vld_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         pend_ff <= pend_in;
         vld_ff  <= vld_in;
      end
      tok_ff   <= tok_in;
      rest_ff  <= rest_in;
      glyph_ff <= glyph_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_glyph  = glyph_ff;
   assign rsp_last   = last_ff;
   assign stat.busy  = busy_ff;
   assign stat.pend  = pend_ff;

endmodule

// File: sv/binary_to_roman_numeral_encoder_core.sv
// top level of the binary to roman numeral encoder
//
// converts one 12-bit binary value per request into its roman numeral, sent
// as a run of ascii letters (M D C L X V I) on the rsp stream, most
// significant letter first, rsp_tlast high on the final letter.
// values 0 and 4000..4095 are taken and dropped without any response.
// requests enter on req_tvalid/req_tready, value in req_tdata[11:0].
// a front register classifies each request and pushes good values into a
// small fifo; the back stage pops one value, loads it into its remainder
// register, then emits one letter per cycle unless the output register is
// stalled by rsp_tready; it takes no new value until the numeral is done.
// the front keeps taking requests while the back works, until the fifo
// and the front register are full.
// an accepted request passes the front register, the fifo and the back stage load before its first letter.
// the letter sits in an output register; when rsp_tready is low it holds and
// the back stage waits, without losing or repeating letters.
// reset (synchronous, active high) empties the front register and the fifo and drops any partial
// numeral; there is no clearing pass.
`timescale 1ns / 1ps
module binary_to_roman_numeral_encoder_core #(
   parameter int QUEUE_DEPTH = rne_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [rne_pkg::REQ_DATA_W-1:0] req_tdata,  // [11:0] value, [15:12] zero
   // response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rne_pkg::GLYPH_W-1:0]    rsp_tdata,  // [7:0] glyph
   output logic                           rsp_tlast
);
   import rne_pkg::*;

   q_entry_type   q_push;
   q_entry_type   q_head;
   logic          q_ready;
   logic          q_pop;
   back_stat_type back_stat;

   // front: request register and range check
   rne_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_value  (req_tdata[VALUE_W-1:0]),
      .q_ready    (q_ready),
      .q_push     (q_push)
   );

   // decoupling fifo
   rne_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_ready (q_ready),
      .q_head  (q_head),
      .q_pop   (q_pop)
   );

   // back: letter generator with output register
   rne_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_glyph  (rsp_tdata),
      .rsp_last   (rsp_tlast),
      .stat       (back_stat)
   );

   // once the final letter is registered, no second letter of a pair is pending
   a_last_frees_back: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !back_stat.pend)
      else $error("back stage still holds a pair letter after last");

   // a pending second letter only exists while a value is in work
   a_pend_needs_busy: assert property (@(posedge clock) disable iff (reset)
      back_stat.pend |-> back_stat.busy)
      else $error("pair letter pending with back stage idle");

   // the first letter of a pair is never marked last
   a_pair_not_last: assert property (@(posedge clock) disable iff (reset)
      $rose(back_stat.pend) |-> rsp_tvalid && !rsp_tlast)
      else $error("first letter of a pair marked last");

   // only numeral letters leave the block
   a_legal_glyph: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata == CHAR_M) || (rsp_tdata == CHAR_D) ||
         (rsp_tdata == CHAR_C) || (rsp_tdata == CHAR_L) || (rsp_tdata == CHAR_X) ||
         (rsp_tdata == CHAR_V) || (rsp_tdata == CHAR_I))
      else $error("illegal numeral letter on response");

endmodule
